[rtl/page_frame_free_list_allocator_assert.svh]
// Assertion macros for the page frame allocator.
// No dependencies; included by the top level only.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PFFLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PFFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pffla_pkg.sv]
// Shared types and constants of the page frame allocator.
// No dependencies; imported by every module.
package pffla_pkg;

    localparam int MAX_PAGES = 64;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int PTR_W     = 7;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [PTR_W-1:0]  END_MARK  = 7'd127;
    localparam logic [PAGE_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [PTR_W-1:0]  TOTAL_MIN = 7'd2;
    localparam logic [PTR_W-1:0]  TOTAL_MAX = 7'd64;

    // action codes of an input request
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_LIST  = 2'd2;

    // register index of total_pages
    localparam logic REG_TOTAL = 1'b0;

    typedef struct packed {
        logic [1:0]        action;
        logic [6:0]        alloc_count;
        logic [PAGE_W-1:0] page_number;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0] page_out;
        logic              ok;
        logic              last;
        logic [PAGE_W-1:0] free_count;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LIST,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [6:0]        count;
        logic [PAGE_W-1:0] page;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_rd;

    typedef struct packed {
        logic             wr;
        logic [PTR_W-1:0] wr_total;
        logic [PTR_W-1:0] total;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    // next pointer of an entry that has not been written since the rebuild
    function automatic logic [PTR_W-1:0] dflt_next(logic [PAGE_W-1:0] a,
                                                   logic [PTR_W-1:0] total);
        logic [PTR_W-1:0] a1;
        a1 = {1'b0, a} + 7'd1;
        if ((a != '0) && (a1 < total)) begin
            return a1;
        end
        return END_MARK;
    endfunction

    // clamp a written total to the supported range
    function automatic logic [PTR_W-1:0] clamp_total(logic [PTR_W-1:0] v);
        if (v < TOTAL_MIN) begin
            return TOTAL_MIN;
        end
        if (v > TOTAL_MAX) begin
            return TOTAL_MAX;
        end
        return v;
    endfunction

endpackage

[rtl/page_frame_free_list_allocator.sv]
// Top level of the page frame allocator: register port and module wiring.
// Depends on pffla_pkg, pffla_front, pffla_queue, pffla_back and the
// assertion macro header.

// LIFO free-list allocator of 64 KiB page frames (byte address = page * 65536).
// Requests enter through a two-entry command queue, so a new request is taken
// while the back end works. Free, refused, zero-count and bad requests give a
// single result, registered in the command queue and then in the result register.
// Allocate and list give one result per page; the registered read of the
// next-pointer table (READ state) comes before each page is emitted (EMIT).
// Writing total_pages (offset 0) rebuilds the free list; no clearing pass is
// needed after reset. Write it only while the block is idle.
`include "page_frame_free_list_allocator_assert.svh"

module page_frame_free_list_allocator import pffla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    input  t_in_item    i_in,
    output logic        o_in_stall,
    // result channel
    output logic        o_out_valid,
    output t_out_item   o_out,
    input  logic        i_out_stall,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [PTR_W-1:0] r_total_pages;
    logic             cfg_wr;
    t_cfg             cfg;
    t_q_wr            q_wr;
    t_q_rd            q_rd;
    logic             q_full;
    logic             q_pop;

    // register write decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages <= TOTAL_MAX;
        end else begin
            if (cfg_wr) begin
                r_total_pages <= clamp_total(pwdata[PTR_W-1:0]);
            end
        end
    end

    assign prdata       = (paddr[2] == REG_TOTAL) ? {25'd0, r_total_pages} : 32'd0;
    assign cfg.wr       = cfg_wr;
    assign cfg.wr_total = clamp_total(pwdata[PTR_W-1:0]);
    assign cfg.total    = r_total_pages;

    pffla_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    pffla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    pffla_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q         (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // back end only takes commands that are present
    `PFFLA_ASSERT_NOW(a_pop_valid, i_clk, i_rst_n, q_pop, q_rd.valid, "pop of empty queue")
    // a refusal is a lone result without a page
    `PFFLA_ASSERT_NOW(a_refuse_form, i_clk, i_rst_n, o_out_valid && !o_out.ok,
        o_out.last && (o_out.page_out == '0), "refusal not final or carries a page")
    // a free request answers in the next cycle
    `PFFLA_ASSERT_NEXT(a_free_answer, i_clk, i_rst_n, q_pop && (q_rd.cmd.op == OP_FREE),
        o_out_valid, "free request gave no result")
    // the front end only pushes when the queue has room
    `PFFLA_ASSERT_NOW(a_push_room, i_clk, i_rst_n, q_wr.push, !q_full,
        "push into full queue")

endmodule

[rtl/pffla_front.sv]
// Front end: takes input requests and classifies them into commands.
// Depends on pffla_pkg; feeds pffla_queue.
module pffla_front import pffla_pkg::*; (
    input  logic     i_in_valid,
    input  t_in_item i_in,
    output logic     o_in_stall,
    input  logic     i_q_full,
    output t_q_wr    o_q_wr
);

    t_op op;

    // decode the action field
    always_comb begin
        case (i_in.action)
            ACT_ALLOC: op = OP_ALLOC;
            ACT_FREE:  op = OP_FREE;
            ACT_LIST:  op = OP_LIST;
            default:   op = OP_BAD;
        endcase
    end

    // push into the command queue while it has room
    assign o_in_stall       = i_q_full;
    assign o_q_wr.push      = i_in_valid && !i_q_full;
    assign o_q_wr.cmd.op    = op;
    assign o_q_wr.cmd.count = i_in.alloc_count;
    assign o_q_wr.cmd.page  = i_in.page_number;

endmodule

[rtl/pffla_queue.sv]
// Two-entry command queue between front end and back end.
// Depends on pffla_pkg.
module pffla_queue import pffla_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    input  logic  i_pop,
    output t_q_rd o_rd
);

    t_cmd               r_ent [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp;
    logic [Q_PTR_W-1:0] r_rp, n_rp;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && (r_cnt != '0);

    // pointer and fill updates
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_wr.cmd;
        end
    end

    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.cmd   = r_ent[r_rp];

endmodule

[rtl/pffla_back.sv]
// Back end: next-pointer table, head, free count and result register.
// Depends on pffla_pkg; drains pffla_queue.
module pffla_back import pffla_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_rd     i_q,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    t_state r_state, n_state;

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PAGE_W-1:0] r_free, n_free;
    logic [PTR_W-1:0]  r_ptr,  n_ptr;
    logic [PAGE_W-1:0] r_left, n_left;
    logic              r_is_alloc, n_is_alloc;

    // next-pointer table with per-entry written marks
    logic [PTR_W-1:0]     r_mem [MAX_PAGES];
    logic [MAX_PAGES-1:0] r_wrote;
    logic [PTR_W-1:0]     r_rdata;
    logic                 r_rd_wrote;
    logic                 mem_we;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic             slot_free;
    logic             emit;
    t_out_item        emit_item;
    logic [PTR_W-1:0] next_ptr;

    assign slot_free = !r_out_valid || !i_out_stall;

    // successor of the walk pointer
    always_comb begin
        if (r_ptr[PTR_W-1]) begin
            next_ptr = END_MARK;
        end else if (r_rd_wrote) begin
            next_ptr = r_rdata;
        end else begin
            next_ptr = dflt_next(r_ptr[PAGE_W-1:0], i_cfg.total);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid && slot_free) begin
                    if ((i_q.cmd.op == OP_ALLOC) && (i_q.cmd.count != '0)
                        && (i_q.cmd.count <= {1'b0, r_free})) begin
                        n_state = ST_READ;
                    end else if ((i_q.cmd.op == OP_LIST) && (r_free != '0)) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = (r_left == PAGE_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and result generation
    always_comb begin
        n_head     = r_head;
        n_free     = r_free;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_is_alloc = r_is_alloc;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        emit       = 1'b0;
        emit_item  = '{page_out: '0, ok: 1'b0, last: 1'b1, free_count: r_free};
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid && slot_free) begin
                    o_pop = 1'b1;
                    case (i_q.cmd.op)
                        OP_ALLOC: begin
                            if (i_q.cmd.count > {1'b0, r_free}) begin
                                emit = 1'b1;
                            end else if (i_q.cmd.count == '0) begin
                                emit         = 1'b1;
                                emit_item.ok = 1'b1;
                            end else begin
                                n_ptr      = r_head;
                                n_left     = i_q.cmd.count[PAGE_W-1:0];
                                n_is_alloc = 1'b1;
                            end
                        end
                        OP_FREE: begin
                            emit = 1'b1;
                            if (r_free != COUNT_MAX) begin
                                mem_we               = 1'b1;
                                n_head               = {1'b0, i_q.cmd.page};
                                n_free               = r_free + 1'b1;
                                emit_item.ok         = 1'b1;
                                emit_item.free_count = r_free + 1'b1;
                            end
                        end
                        OP_LIST: begin
                            if (r_free == '0) begin
                                emit         = 1'b1;
                                emit_item.ok = 1'b1;
                            end else begin
                                n_ptr      = r_head;
                                n_left     = r_free;
                                n_is_alloc = 1'b0;
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    emit               = 1'b1;
                    emit_item.ok       = 1'b1;
                    emit_item.last     = (r_left == PAGE_W'(1));
                    emit_item.page_out = r_ptr[PTR_W-1] ? '0 : r_ptr[PAGE_W-1:0];
                    n_ptr              = next_ptr;
                    n_left             = r_left - 1'b1;
                    if (r_is_alloc) begin
                        n_head               = next_ptr;
                        n_free               = r_free - 1'b1;
                        emit_item.free_count = r_free - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        // rebuild of the free list on a total_pages write
        if (i_cfg.wr) begin
            n_head = 7'd1;
            n_free = PAGE_W'(i_cfg.wr_total - 7'd1);
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = emit_item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= 7'd1;
            r_free      <= PAGE_W'(TOTAL_MAX - 7'd1);
            r_out_valid <= 1'b0;
            r_is_alloc  <= 1'b0;
            r_left      <= '0;
            r_ptr       <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            r_is_alloc  <= n_is_alloc;
            r_left      <= n_left;
            r_ptr       <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // written marks, cleared by reset and by a rebuild
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.wr) begin
            r_wrote <= '0;
        end else if (mem_we) begin
            r_wrote[i_q.cmd.page] <= 1'b1;
        end
    end

    // table write on free, registered read for the walk
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q.cmd.page] <= r_head;
        end
        if (r_state == ST_READ) begin
            r_rdata    <= r_mem[r_ptr[PAGE_W-1:0]];
            r_rd_wrote <= r_wrote[r_ptr[PAGE_W-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[bench/tb_page_frame_free_list_allocator.sv]
// Self-checking bench for the page frame free-list allocator: directed and random requests.
// Predicts every result with its own free-list model.
// Depends on pffla_pkg and the page_frame_free_list_allocator top level.
`timescale 1ns / 1ps

module tb_page_frame_free_list_allocator;
    import pffla_pkg::*;

    localparam logic [1:0] ACT_BAD    = 2'd3;
    localparam logic [2:0] TOTAL_ADDR = 3'(REG_TOTAL) * 3'd4;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out;
    logic        i_out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    page_frame_free_list_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // free-list model state
    logic [PTR_W-1:0] mdl_next [MAX_PAGES];
    logic [PTR_W-1:0] mdl_head;
    logic [PTR_W-1:0] mdl_free;
    logic [PTR_W-1:0] mdl_total;

    t_out_item        frame_results_due[$];
    logic [PAGE_W-1:0] held_pages[$];   // pages handed out, candidates for a clean free
    int               error_count;
    bit               steady_traffic;   // no idling while set

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_traffic || r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // ---------------------------------------------------------------
    // free-list model
    // ---------------------------------------------------------------
    function automatic logic [PTR_W-1:0] next_of(input logic [PTR_W-1:0] p);
        if (p >= PTR_W'(MAX_PAGES)) begin
            return END_MARK;
        end
        return mdl_next[p[PAGE_W-1:0]];
    endfunction

    function automatic logic [PAGE_W-1:0] frame_of(input logic [PTR_W-1:0] p);
        return (p >= PTR_W'(MAX_PAGES)) ? '0 : p[PAGE_W-1:0];
    endfunction

    function automatic void rebuild_free_list(input logic [31:0] value);
        logic [PTR_W-1:0] t;
        t = value[PTR_W-1:0];
        if (t < TOTAL_MIN) t = TOTAL_MIN;
        if (t > TOTAL_MAX) t = TOTAL_MAX;
        mdl_total = t;
        for (int i = 0; i < MAX_PAGES; i++) mdl_next[i] = END_MARK;
        for (int i = 1; i + 1 < int'(t); i++) mdl_next[i] = PTR_W'(i + 1);
        mdl_head = 7'd1;
        mdl_free = t - 7'd1;
        held_pages.delete();
    endfunction

    function automatic void owe_result(input logic [PAGE_W-1:0] page, input logic ok,
                                       input logic last);
        t_out_item res;
        res.page_out   = page;
        res.ok         = ok;
        res.last       = last;
        res.free_count = (mdl_free > {1'b0, COUNT_MAX}) ? COUNT_MAX : mdl_free[PAGE_W-1:0];
        frame_results_due.insert(frame_results_due.size(), res);
    endfunction

    function automatic void apply_page_request(input t_in_item req);
        logic [PTR_W-1:0] p;
        int n;
        case (req.action)
            ACT_ALLOC: begin
                if (req.alloc_count > mdl_free) begin
                    owe_result('0, 1'b0, 1'b1);
                end else if (req.alloc_count == 0) begin
                    owe_result('0, 1'b1, 1'b1);
                end else begin
                    for (int i = 0; i < int'(req.alloc_count) && i < 63; i++) begin
                        p = mdl_head;
                        mdl_head = next_of(p);
                        mdl_free = mdl_free - 7'd1;
                        owe_result(frame_of(p), 1'b1, (i + 1 == int'(req.alloc_count)));
                        if (frame_of(p) != 0) held_pages.insert(held_pages.size(), frame_of(p));
                    end
                end
            end
            ACT_FREE: begin
                if (mdl_free >= {1'b0, COUNT_MAX} ||
                    {1'b0, req.page_number} >= PTR_W'(MAX_PAGES)) begin
                    owe_result('0, 1'b0, 1'b1);
                end else begin
                    mdl_next[req.page_number] = mdl_head;
                    mdl_head = {1'b0, req.page_number};
                    mdl_free = mdl_free + 7'd1;
                    owe_result('0, 1'b1, 1'b1);
                end
            end
            ACT_LIST: begin
                if (mdl_free == 0) begin
                    owe_result('0, 1'b1, 1'b1);
                end else begin
                    n = (mdl_free > {1'b0, COUNT_MAX}) ? int'(COUNT_MAX) : int'(mdl_free);
                    p = mdl_head;
                    for (int i = 0; i < n; i++) begin
                        owe_result(frame_of(p), 1'b1, (i + 1 == n));
                        p = next_of(p);
                    end
                end
            end
            default: owe_result('0, 1'b0, 1'b1);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // request driver, result stall, result checker
    // ---------------------------------------------------------------
    task automatic send_request(input logic [1:0] action, input logic [6:0] count,
                                input logic [PAGE_W-1:0] page);
        t_in_item req;
        int gap;
        req.action      = action;
        req.alloc_count = count;
        req.page_number = page;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        apply_page_request(req);
    endtask

    // drop valid and let every owed result drain
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_total_pages(input logic [31:0] value);
        wait_until_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOTAL_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rebuild_free_list(value);
    endtask

    // result-side stall pattern
    initial begin : result_stall_gen
        int hold;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // compare each accepted result with the oldest owed one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result page %0d ok %0b last %0b count %0d",
                                          o_out.page_out, o_out.ok, o_out.last,
                                          o_out.free_count));
            end else begin
                want = frame_results_due.pop_front();
                if (o_out.page_out !== want.page_out)
                    report_mismatch($sformatf("page_out got %0d want %0d",
                                              o_out.page_out, want.page_out));
                if (o_out.ok !== want.ok)
                    report_mismatch($sformatf("ok got %0b want %0b", o_out.ok, want.ok));
                if (o_out.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b", o_out.last, want.last));
                if (o_out.free_count !== want.free_count)
                    report_mismatch($sformatf("free_count got %0d want %0d",
                                              o_out.free_count, want.free_count));
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // full list out of reset, refusals, drain to empty, odd frees
    task automatic test_reset_state();
        send_request(ACT_LIST,  7'd0,   6'd0);
        send_request(ACT_FREE,  7'd0,   6'd5);     // count at its ceiling: refused
        send_request(ACT_ALLOC, 7'd0,   6'd0);
        send_request(ACT_ALLOC, 7'd64,  6'd63);    // one more than free
        send_request(ACT_ALLOC, 7'd127, 6'd0);
        send_request(ACT_ALLOC, 7'd63,  6'd0);     // take every page
        send_request(ACT_LIST,  7'd0,   6'd0);     // empty list
        send_request(ACT_ALLOC, 7'd1,   6'd0);     // nothing left
        send_request(ACT_FREE,  7'd0,   6'd0);     // reserved page is pushed anyway
        send_request(ACT_FREE,  7'd0,   6'd63);
        send_request(ACT_BAD,   7'd127, 6'd63);
        send_request(ACT_LIST,  7'd0,   6'd0);
        send_request(ACT_FREE,  7'd0,   6'd63);    // double free makes a loop
        send_request(ACT_ALLOC, 7'd3,   6'd0);
    endtask

    // clamped and extreme totals
    task automatic test_config_extremes();
        write_total_pages(32'd0);                  // clamps to the minimum
        send_request(ACT_LIST,  7'd0, 6'd0);
        send_request(ACT_ALLOC, 7'd2, 6'd0);
        send_request(ACT_ALLOC, 7'd1, 6'd0);
        send_request(ACT_FREE,  7'd0, 6'd1);
        write_total_pages(32'd127);                // clamps to the maximum
        send_request(ACT_ALLOC, 7'd1, 6'd0);
        write_total_pages(32'd1);
        send_request(ACT_LIST,  7'd0, 6'd0);
    endtask

    // one phase of mostly well-formed alloc/free traffic plus noise
    task automatic test_random_traffic(input logic [31:0] total, input bit steady);
        int r;
        int idx;
        int hi;
        logic [PAGE_W-1:0] pg;
        write_total_pages(total);
        steady_traffic = steady;
        for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                hi = (r < 5) ? int'(mdl_free) : ((mdl_free < 6) ? int'(mdl_free) : 6);
                send_request(ACT_ALLOC, (hi == 0) ? 7'd0 : 7'($urandom_range(1, hi)),
                             6'($urandom));
            end else if (r < 70) begin
                if (held_pages.size() != 0) begin
                    idx = $urandom_range(0, held_pages.size() - 1);
                    pg = held_pages[idx];
                    held_pages.delete(idx);
                end else begin
                    pg = 6'($urandom_range(1, int'(mdl_total) - 1));
                end
                send_request(ACT_FREE, 7'($urandom), pg);
            end else if (r < 80) begin
                send_request(ACT_LIST, 7'($urandom), 6'($urandom));
            end else begin
                send_request(2'($urandom), 7'($urandom), 6'($urandom));
            end
        end
        steady_traffic = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        error_count    = 0;
        steady_traffic = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        rebuild_free_list(32'd64);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_config_extremes();
        test_random_traffic(32'd64, 1'b0);
        test_random_traffic(32'd2, 1'b0);
        test_random_traffic(32'h0000_0105, 1'b1);  // upper bits ignored
        test_random_traffic(32'($urandom_range(3, 12)), 1'b0);
        test_random_traffic(32'($urandom_range(2, 64)), 1'b0);
        test_random_traffic(32'd100, 1'b0);

        wait_until_idle();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
